// File: src/tbo_pkg.sv
// Shared constants for the triangle-box overlap block
package tbo_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 20;

    // configuration register map, one register per 32-bit word
    localparam int NUM_REGS     = 7;
    localparam int REG_MIN_BASE = 0;
    localparam int REG_MAX_BASE = 3;
    localparam int REG_MARGIN   = 6;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    // number of register stages from input to result
    localparam int NUM_STAGES = 7;

endpackage

// File: src/tbo_tri_if.sv
// Triangle item channel: three vertices of signed coordinates
interface tbo_tri_if import tbo_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

// File: src/tbo_res_if.sv
// Result item channel: one overlap flag per triangle
interface tbo_res_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, overlaps, input ready);
    modport sink   (input valid, overlaps, output ready);
endinterface

// File: src/triangle_box_overlap_test_core.sv
// Triangle versus box separating-axis overlap test, seven-stage pipeline
//
//  channel   dir  handshake           payload
//  i_tri     in   valid/ready         ax ay az bx by bz cx cy cz (signed)
//  o_res     out  valid/ready         overlaps
//  APB       in   psel/penable/pwrite box_min_xyz, box_max_xyz, grow_margin
//
// One item enters per cycle while the output is not stalled; each result passes
// through the registers of stages 0 to 6 before it is presented. The depth is set
// by the normal axis: cross products, then a split wide multiply, then the sum.
// Reset clears the valid bits and the box registers; no clearing pass.
// Each full stage holds while the next one is full and stalled, so a stall at
// the output fills bubbles first and then lowers ready.
module triangle_box_overlap_test_core import tbo_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tbo_tri_if.sink               i_tri,
    tbo_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int N   = COORD_BITS;
    localparam int LW  = N + 1;          // bounds and edges
    localparam int PW  = 2 * LW;         // edge products
    localparam int NW  = PW + 1;         // normal components, projections
    localparam int K   = N + 2;          // split point of normal components
    localparam int HW  = NW - K;         // upper part of a normal component
    localparam int LPW = K + 1 + LW;     // lower partial product
    localparam int HPW = HW + LW;        // upper partial product
    localparam int DW  = HPW + 2 + K + 1; // full normal projection
    localparam int IW  = APB_ADDR_W - 2;

    // configuration registers
    logic signed [N-1:0] r_cfg [NUM_REGS];
    logic [IW-1:0]       w_idx;
    logic                w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGS; r++) r_cfg[r] <= '0;
        end else if (w_wr && (int'(w_idx) < NUM_REGS)) begin
            r_cfg[w_idx] <= pwdata[N-1:0];
        end
    end

    // read back, sign-extended
    always_comb begin
        prdata = '0;
        if (int'(w_idx) < NUM_REGS) prdata = APB_DATA_W'(r_cfg[w_idx]);
    end

    // stage flow control: a stage moves when empty or when its successor moves
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_res.ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--) w_en[s] = !r_vld[s] || w_en[s+1];
    end

    assign i_tri.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_tri.valid;
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // stage 0: capture vertices, grow the box
    logic signed [N-1:0]  w_p  [3][3];
    logic signed [N-1:0]  r0_p [3][3];
    logic signed [LW-1:0] r0_lo [3];
    logic signed [LW-1:0] r0_hi [3];

    always_comb begin
        w_p[0][0] = i_tri.ax; w_p[0][1] = i_tri.ay; w_p[0][2] = i_tri.az;
        w_p[1][0] = i_tri.bx; w_p[1][1] = i_tri.by; w_p[1][2] = i_tri.bz;
        w_p[2][0] = i_tri.cx; w_p[2][1] = i_tri.cy; w_p[2][2] = i_tri.cz;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_p <= w_p;
            for (int j = 0; j < 3; j++) begin
                r0_lo[j] <= LW'(r_cfg[REG_MIN_BASE+j]) - LW'(r_cfg[REG_MARGIN]);
                r0_hi[j] <= LW'(r_cfg[REG_MAX_BASE+j]) + LW'(r_cfg[REG_MARGIN]);
            end
        end
    end

    // stage 1: edges, vertex containment, extent rejection
    logic signed [LW-1:0] r1_p  [3][3];
    logic signed [LW-1:0] r1_e  [3][3];
    logic signed [LW-1:0] r1_lo [3];
    logic signed [LW-1:0] r1_hi [3];
    logic                 r1_in;
    logic                 r1_out;
    logic                 n1_in;
    logic                 n1_out;

    always_comb begin
        logic vin;
        logic all_lt;
        logic all_gt;
        n1_in  = 1'b0;
        n1_out = 1'b0;
        for (int v = 0; v < 3; v++) begin
            vin = 1'b1;
            for (int j = 0; j < 3; j++) begin
                if (LW'(r0_p[v][j]) < r0_lo[j] || LW'(r0_p[v][j]) > r0_hi[j]) vin = 1'b0;
            end
            n1_in = n1_in | vin;
        end
        for (int j = 0; j < 3; j++) begin
            all_lt = 1'b1;
            all_gt = 1'b1;
            for (int v = 0; v < 3; v++) begin
                if (!(LW'(r0_p[v][j]) < r0_lo[j])) all_lt = 1'b0;
                if (!(LW'(r0_p[v][j]) > r0_hi[j])) all_gt = 1'b0;
            end
            n1_out = n1_out | all_lt | all_gt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int v = 0; v < 3; v++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_p[v][j] <= LW'(r0_p[v][j]);
                    r1_e[v][j] <= LW'(r0_p[(v+1)%3][j]) - LW'(r0_p[v][j]);
                end
            end
            // order each pair of bounds so corner selection holds on an inverted box
            for (int j = 0; j < 3; j++) begin
                r1_lo[j] <= (r0_lo[j] > r0_hi[j]) ? r0_hi[j] : r0_lo[j];
                r1_hi[j] <= (r0_lo[j] > r0_hi[j]) ? r0_lo[j] : r0_hi[j];
            end
            r1_in  <= n1_in;
            r1_out <= n1_out;
        end
    end

    // stage 2: products for the edge axes, each edge crossed with each box axis, and the normal
    logic signed [PW-1:0] r2_pb  [3][3][3];
    logic signed [PW-1:0] r2_pa  [3][3][3];
    logic signed [PW-1:0] r2_bx1 [3][3];
    logic signed [PW-1:0] r2_bx2 [3][3];
    logic signed [PW-1:0] r2_bn1 [3][3];
    logic signed [PW-1:0] r2_bn2 [3][3];
    logic signed [PW-1:0] r2_nm1 [3];
    logic signed [PW-1:0] r2_nm2 [3];
    logic signed [LW-1:0] r2_p0  [3];
    logic signed [LW-1:0] r2_lo  [3];
    logic signed [LW-1:0] r2_hi  [3];
    logic                 r2_in;
    logic                 r2_out;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    for (int v = 0; v < 3; v++) begin
                        r2_pb[k][i][v] <= PW'(r1_e[i][(k+1)%3]) * PW'(r1_p[v][(k+2)%3]);
                        r2_pa[k][i][v] <= PW'(r1_e[i][(k+2)%3]) * PW'(r1_p[v][(k+1)%3]);
                    end
                    // pick the box corner that extremises each term
                    r2_bx1[k][i] <= PW'(r1_e[i][(k+1)%3]) * PW'(
                        r1_e[i][(k+1)%3] >= 0 ? r1_hi[(k+2)%3] : r1_lo[(k+2)%3]);
                    r2_bx2[k][i] <= PW'(r1_e[i][(k+2)%3]) * PW'(
                        r1_e[i][(k+2)%3] >= 0 ? r1_lo[(k+1)%3] : r1_hi[(k+1)%3]);
                    r2_bn1[k][i] <= PW'(r1_e[i][(k+1)%3]) * PW'(
                        r1_e[i][(k+1)%3] >= 0 ? r1_lo[(k+2)%3] : r1_hi[(k+2)%3]);
                    r2_bn2[k][i] <= PW'(r1_e[i][(k+2)%3]) * PW'(
                        r1_e[i][(k+2)%3] >= 0 ? r1_hi[(k+1)%3] : r1_lo[(k+1)%3]);
                end
            end
            for (int j = 0; j < 3; j++) begin
                r2_nm1[j] <= PW'(r1_e[0][(j+1)%3]) * PW'(r1_e[1][(j+2)%3]);
                r2_nm2[j] <= PW'(r1_e[0][(j+2)%3]) * PW'(r1_e[1][(j+1)%3]);
            end
            r2_p0  <= r1_p[0];
            r2_lo  <= r1_lo;
            r2_hi  <= r1_hi;
            r2_in  <= r1_in;
            r2_out <= r1_out;
        end
    end

    // stage 3: edge-axis separation, normal components
    logic signed [NW-1:0] r3_n  [3];
    logic signed [LW-1:0] r3_p0 [3];
    logic signed [LW-1:0] r3_lo [3];
    logic signed [LW-1:0] r3_hi [3];
    logic                 r3_in;
    logic                 r3_out;
    logic                 r3_sep;
    logic                 n3_sep;

    always_comb begin
        logic signed [NW-1:0] bmx;
        logic signed [NW-1:0] bmn;
        logic signed [NW-1:0] pj;
        logic                 all_lt;
        logic                 all_gt;
        n3_sep = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                bmx    = NW'(r2_bx1[k][i]) - NW'(r2_bx2[k][i]);
                bmn    = NW'(r2_bn1[k][i]) - NW'(r2_bn2[k][i]);
                all_lt = 1'b1;
                all_gt = 1'b1;
                for (int v = 0; v < 3; v++) begin
                    pj = NW'(r2_pb[k][i][v]) - NW'(r2_pa[k][i][v]);
                    if (!(pj < bmn)) all_lt = 1'b0;
                    if (!(pj > bmx)) all_gt = 1'b0;
                end
                n3_sep = n3_sep | all_lt | all_gt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int j = 0; j < 3; j++) r3_n[j] <= NW'(r2_nm1[j]) - NW'(r2_nm2[j]);
            r3_p0  <= r2_p0;
            r3_lo  <= r2_lo;
            r3_hi  <= r2_hi;
            r3_in  <= r2_in;
            r3_out <= r2_out;
            r3_sep <= n3_sep;
        end
    end

    // stage 4: normal times vertex and box corners, split in two halves
    // operand 0 is the vertex, 1 the max corner, 2 the min corner
    logic signed [LPW-1:0] r4_l [3][3];
    logic signed [HPW-1:0] r4_h [3][3];
    logic                  r4_in;
    logic                  r4_out;
    logic                  r4_sep;
    logic signed [LW-1:0]  w4_c  [3][3];
    logic signed [K:0]     w4_nl [3];
    logic signed [HW-1:0]  w4_nh [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w4_nl[j]   = $signed({1'b0, r3_n[j][K-1:0]});
            w4_nh[j]   = r3_n[j][NW-1:K];
            w4_c[0][j] = r3_p0[j];
            w4_c[1][j] = (r3_n[j] >= 0) ? r3_hi[j] : r3_lo[j];
            w4_c[2][j] = (r3_n[j] >= 0) ? r3_lo[j] : r3_hi[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int o = 0; o < 3; o++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_l[o][j] <= LPW'(w4_nl[j]) * LPW'(w4_c[o][j]);
                    r4_h[o][j] <= HPW'(w4_nh[j]) * HPW'(w4_c[o][j]);
                end
            end
            r4_in  <= r3_in;
            r4_out <= r3_out;
            r4_sep <= r3_sep;
        end
    end

    // stage 5: sum the halves over the three components
    logic signed [LPW+1:0] r5_sl [3];
    logic signed [HPW+1:0] r5_sh [3];
    logic                  r5_in;
    logic                  r5_out;
    logic                  r5_sep;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int o = 0; o < 3; o++) begin
                r5_sl[o] <= (LPW+2)'(r4_l[o][0]) + (LPW+2)'(r4_l[o][1])
                          + (LPW+2)'(r4_l[o][2]);
                r5_sh[o] <= (HPW+2)'(r4_h[o][0]) + (HPW+2)'(r4_h[o][1])
                          + (HPW+2)'(r4_h[o][2]);
            end
            r5_in  <= r4_in;
            r5_out <= r4_out;
            r5_sep <= r4_sep;
        end
    end

    // stage 6: join halves, test the normal axis, decide
    logic                 r_ovl;
    logic                 n6_ovl;
    logic signed [DW-1:0] w6_t [3];

    always_comb begin
        for (int o = 0; o < 3; o++) begin
            w6_t[o] = (DW'(r5_sh[o]) <<< K) + DW'(r5_sl[o]);
        end
        n6_ovl = r5_in || (!r5_out && !r5_sep && !(w6_t[0] > w6_t[1])
                           && !(w6_t[0] < w6_t[2]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) r_ovl <= n6_ovl;
    end

    assign o_res.valid    = r_vld[NUM_STAGES-1];
    assign o_res.overlaps = r_ovl;

    // a vertex inside the box cannot also have every vertex beyond one face
    a_in_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> !(r1_in && r1_out))
        else $error("containment and extent rejection both set");

    // input is refused only behind a full, stalled pipeline
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tri.ready |-> (&r_vld) && !o_res.ready)
        else $error("input stalled with room in the pipeline");

    // a contained vertex always yields overlap
    a_in_ovl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && r5_in && w_en[6] |=> o_res.valid && o_res.overlaps)
        else $error("contained vertex reported without overlap");

endmodule
